>>> hdl/ecda_pkg.sv
`default_nettype none
package ecda_pkg;

  localparam int THR_W     = 31;
  localparam int READING_W = 24;
  localparam int PHASE_W   = 2;
  localparam int DELTA_W   = 25;
  localparam int SUM_W     = 32;
  localparam int CFG_IDX_W = 1;
  localparam int SLOT_W    = 3;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(1000);

  localparam logic signed [SUM_W-1:0] SUM_MAX = 32'sh7fff_ffff;
  localparam logic signed [SUM_W-1:0] SUM_MIN = 32'sh8000_0000;

  localparam logic MODE_ACTIVE   = 1'b0;
  localparam logic MODE_REACTIVE = 1'b1;

  localparam logic [PHASE_W-1:0] PHASE_SWEEP_END = 2'd2;
  localparam logic [PHASE_W-1:0] PHASE_UNUSED    = 2'd3;

  localparam logic [SLOT_W-1:0] SLOTS_PER_KIND = 3'd3;
  localparam int               NUM_SLOTS      = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_THR   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REACTIVE_THR = 1'd1;

endpackage
`default_nettype wire

>>> hdl/energy_counter_delta_accumulator_unit.sv
`default_nettype none
// Energy counter delta accumulator. Each input beat carries one raw energy-register reading
// for phase 0..2 of active (mode 0) or reactive (mode 1) energy. The unit keeps the last
// reading per phase and kind, forms the counter-wrap corrected signed delta (none on the first
// reading of a slot), adds it to that kind's saturating 32-bit accumulator and, on a phase-2
// beat, takes one threshold toward zero and counts a unit when the accumulator magnitude
// exceeds the threshold (active energy only with load_present set). Phase 3 beats change no
// state. One beat is accepted every cycle while the output is not stalled; a result passes
// one input register and one result register, with the single pass through the subtract,
// add-saturate and threshold logic in between. Thresholds reset to 1000; the user must write
// them via cfg_we/cfg_index/cfg_data only while the unit is idle, which it does not enforce.
module energy_counter_delta_accumulator_unit #(
  parameter int COUNTER_BITS = 24
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [ecda_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ecda_pkg::THR_W-1:0]       cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             in_mode,
  input  wire logic [ecda_pkg::PHASE_W-1:0]     in_phase_index,
  input  wire logic [ecda_pkg::READING_W-1:0]   in_reading,
  input  wire logic                             in_load_present,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  out_delta_valid,
  output logic signed [ecda_pkg::DELTA_W-1:0]   out_wrapped_delta,
  output logic signed [ecda_pkg::SUM_W-1:0]     out_accumulator_now,
  output logic                                  out_unit_pulse,
  output logic [ecda_pkg::SUM_W-1:0]            out_unit_total
);
  import ecda_pkg::*;

  localparam int CB = COUNTER_BITS;
  localparam int DW = COUNTER_BITS + 1;
  localparam int SW = (DW + 1 > SUM_W + 2) ? DW + 1 : SUM_W + 2;
  localparam logic [CB-1:0] HALF_PAT = {1'b1, {(CB-1){1'b0}}};

  logic                   s1_valid_r;
  logic                   s1_mode_r;
  logic [PHASE_W-1:0]     s1_phase_r;
  logic [READING_W-1:0]   s1_reading_r;
  logic                   s1_load_r;

  logic [THR_W-1:0]       active_thr_r;
  logic [THR_W-1:0]       reactive_thr_r;
  logic [CB-1:0]          last_reading_r [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]   seen_r;
  logic signed [SUM_W-1:0] active_sum_r;
  logic signed [SUM_W-1:0] reactive_sum_r;
  logic [SUM_W-1:0]       active_units_r;
  logic [SUM_W-1:0]       reactive_units_r;

  logic                   out_valid_r;
  logic                   out_delta_valid_r;
  logic signed [DELTA_W-1:0] out_wrapped_delta_r;
  logic signed [SUM_W-1:0] out_accumulator_now_r;
  logic                   out_unit_pulse_r;
  logic [SUM_W-1:0]       out_unit_total_r;

  logic                   advance;
  logic                   fire;
  logic                   in_range;
  logic [SLOT_W-1:0]      slot;
  logic [CB-1:0]          rd;
  logic [CB-1:0]          last_rd;
  logic [DW-1:0]          diff;
  logic [CB-1:0]          diff_lo;
  logic signed [DW-1:0]   delta;
  logic                   take;
  logic signed [DW-1:0]   delta_eff;
  logic signed [SUM_W-1:0] sum_cur;
  logic signed [SW-1:0]   sum_wide;
  logic signed [SUM_W-1:0] sum_sat;
  logic [THR_W-1:0]       thr;
  logic signed [SUM_W:0]  sum_x;
  logic signed [SUM_W:0]  thr_x;
  logic                   gate;
  logic                   pulse;
  logic signed [SUM_W-1:0] thr_s;
  logic signed [SUM_W-1:0] sum_nxt;
  logic [SUM_W-1:0]       units_cur;
  logic [SUM_W-1:0]       units_nxt;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign fire     = s1_valid_r && advance;

  assign in_range = s1_phase_r != PHASE_UNUSED;
  assign slot     = (s1_mode_r == MODE_REACTIVE) ? SLOT_W'(s1_phase_r) + SLOTS_PER_KIND
                                                 : SLOT_W'(s1_phase_r);
  assign rd       = CB'(s1_reading_r);

  always_comb begin
    last_rd = '0;
    if (in_range) begin
      last_rd = last_reading_r[slot];
    end
  end

  assign diff    = {1'b0, rd} - {1'b0, last_rd};
  assign diff_lo = diff[CB-1:0];

  always_comb begin
    if (diff_lo == HALF_PAT && diff[CB]) begin
      delta = signed'({1'b0, diff_lo});
    end else begin
      delta = signed'({diff_lo[CB-1], diff_lo});
    end
  end

  assign take      = in_range && seen_r[slot];
  assign delta_eff = take ? delta : '0;

  assign sum_cur  = (s1_mode_r == MODE_REACTIVE) ? reactive_sum_r : active_sum_r;
  assign sum_wide = SW'(sum_cur) + SW'(delta_eff);

  always_comb begin
    if (sum_wide > SW'(SUM_MAX)) begin
      sum_sat = SUM_MAX;
    end else if (sum_wide < SW'(SUM_MIN)) begin
      sum_sat = SUM_MIN;
    end else begin
      sum_sat = SUM_W'(sum_wide);
    end
  end

  assign thr   = (s1_mode_r == MODE_REACTIVE) ? reactive_thr_r : active_thr_r;
  assign sum_x = (SUM_W + 1)'(sum_sat);
  assign thr_x = signed'({2'b00, thr});
  assign thr_s = signed'({1'b0, thr});
  assign gate  = in_range && s1_phase_r == PHASE_SWEEP_END &&
                 (s1_mode_r == MODE_REACTIVE || s1_load_r);
  assign pulse = gate && (sum_x > thr_x || sum_x < -thr_x);

  always_comb begin
    sum_nxt = sum_sat;
    if (pulse) begin
      if (sum_sat[SUM_W-1]) begin
        sum_nxt = sum_sat + thr_s;
      end else begin
        sum_nxt = sum_sat - thr_s;
      end
    end
  end

  assign units_cur = (s1_mode_r == MODE_REACTIVE) ? reactive_units_r : active_units_r;
  assign units_nxt = units_cur + SUM_W'(pulse);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
      active_thr_r     <= THR_RESET;
      reactive_thr_r   <= THR_RESET;
      seen_r           <= '0;
      active_sum_r     <= '0;
      reactive_sum_r   <= '0;
      active_units_r   <= '0;
      reactive_units_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ACTIVE_THR:   active_thr_r   <= cfg_data;
          CFG_REACTIVE_THR: reactive_thr_r <= cfg_data;
          default: ;
        endcase
      end
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (fire && in_range) begin
        seen_r[slot] <= 1'b1;
        if (s1_mode_r == MODE_REACTIVE) begin
          reactive_sum_r   <= sum_nxt;
          reactive_units_r <= units_nxt;
        end else begin
          active_sum_r   <= sum_nxt;
          active_units_r <= units_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_mode_r    <= in_mode;
      s1_phase_r   <= in_phase_index;
      s1_reading_r <= in_reading;
      s1_load_r    <= in_load_present;
    end
    if (fire) begin
      if (in_range) begin
        last_reading_r[slot] <= rd;
      end
      out_delta_valid_r     <= take;
      out_wrapped_delta_r   <= DELTA_W'(delta_eff);
      out_accumulator_now_r <= in_range ? sum_nxt : sum_cur;
      out_unit_pulse_r      <= pulse;
      out_unit_total_r      <= in_range ? units_nxt : units_cur;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_delta_valid     = out_delta_valid_r;
  assign out_wrapped_delta   = out_wrapped_delta_r;
  assign out_accumulator_now = out_accumulator_now_r;
  assign out_unit_pulse      = out_unit_pulse_r;
  assign out_unit_total      = out_unit_total_r;

endmodule
`default_nettype wire

>>> sim/tb_top.sv
`default_nettype none
module tb_top;
  import ecda_pkg::*;

  localparam int     HOLD_CYCLES  = 120;
  localparam int     DRAIN_CYCLES = 4;
  localparam int     REPORT_LIMIT = 10;
  localparam longint FULL_SPAN    = longint'(1) << READING_W;
  localparam longint HALF_SPAN    = (longint'(1) << (READING_W - 1)) - 1;
  localparam logic [THR_W-1:0] THR_MAX = '1;

  typedef struct {
    logic                      delta_valid;
    logic signed [DELTA_W-1:0] wrapped_delta;
    logic signed [SUM_W-1:0]   accumulator_now;
    logic                      unit_pulse;
    logic [SUM_W-1:0]          unit_total;
  } meter_result_t;

  logic                 clk             = 1'b0;
  logic                 rst_n           = 1'b0;
  logic                 cfg_we          = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index       = CFG_ACTIVE_THR;
  logic [THR_W-1:0]     cfg_data        = '0;
  logic                 in_valid        = 1'b0;
  logic                 in_mode         = MODE_ACTIVE;
  logic [PHASE_W-1:0]   in_phase_index  = '0;
  logic [READING_W-1:0] in_reading      = '0;
  logic                 in_load_present = 1'b0;
  logic                 out_stall       = 1'b0;

  logic                      in_stall;
  logic                      out_valid;
  logic                      out_delta_valid;
  logic signed [DELTA_W-1:0] out_wrapped_delta;
  logic signed [SUM_W-1:0]   out_accumulator_now;
  logic                      out_unit_pulse;
  logic [SUM_W-1:0]          out_unit_total;

  // predicted meter state
  logic [READING_W-1:0]    slot_last [NUM_SLOTS];
  logic                    slot_seen [NUM_SLOTS];
  logic signed [SUM_W-1:0] kind_sum [2];
  logic [SUM_W-1:0]        kind_units [2];
  logic [THR_W-1:0]        kind_thr [2];

  logic [READING_W-1:0] meter_pos [NUM_SLOTS];
  meter_result_t        pending_results [$];

  int readings_sent      = 0;
  int results_checked    = 0;
  int mismatch_count     = 0;
  int pulses_seen        = 0;
  int input_stall_cycles = 0;
  int hold_req_count     = 0;
  int hold_done_count    = 0;
  int burst_left         = 0;
  bit sender_gaps_on     = 1'b1;

  energy_counter_delta_accumulator_unit #(
    .COUNTER_BITS(READING_W)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_mode             (in_mode),
    .in_phase_index      (in_phase_index),
    .in_reading          (in_reading),
    .in_load_present     (in_load_present),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_delta_valid     (out_delta_valid),
    .out_wrapped_delta   (out_wrapped_delta),
    .out_accumulator_now (out_accumulator_now),
    .out_unit_pulse      (out_unit_pulse),
    .out_unit_total      (out_unit_total)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic signed [SUM_W-1:0] clamp_sum(input longint v);
    if (v > longint'(SUM_MAX)) return SUM_MAX;
    if (v < longint'(SUM_MIN)) return SUM_MIN;
    return SUM_W'(v);
  endfunction

  function automatic meter_result_t predict_meter_step(input logic kind,
                                                       input logic [PHASE_W-1:0] ph,
                                                       input logic [READING_W-1:0] rd,
                                                       input logic lp);
    meter_result_t r;
    int            slot;
    longint        diff;
    longint        acc;
    longint        mag;
    longint        thr;
    r.delta_valid   = 1'b0;
    r.wrapped_delta = '0;
    r.unit_pulse    = 1'b0;
    if (ph != PHASE_UNUSED) begin
      slot = int'(kind) * int'(SLOTS_PER_KIND) + int'(ph);
      if (slot_seen[slot]) begin
        diff = longint'(rd) - longint'(slot_last[slot]);
        if (diff > HALF_SPAN || diff < -HALF_SPAN) begin
          diff = (diff > 0) ? diff - FULL_SPAN : diff + FULL_SPAN;
        end
        kind_sum[kind]  = clamp_sum(longint'(kind_sum[kind]) + diff);
        r.delta_valid   = 1'b1;
        r.wrapped_delta = DELTA_W'(diff);
      end
      slot_seen[slot] = 1'b1;
      slot_last[slot] = rd;
      if (ph == PHASE_SWEEP_END && (kind == MODE_REACTIVE || lp)) begin
        acc = longint'(kind_sum[kind]);
        mag = (acc < 0) ? -acc : acc;
        thr = longint'(kind_thr[kind]);
        if (mag > thr) begin
          acc = (acc > 0) ? acc - thr : acc + thr;
          kind_sum[kind]   = clamp_sum(acc);
          kind_units[kind] = kind_units[kind] + SUM_W'(1);
          r.unit_pulse     = 1'b1;
        end
      end
    end
    r.accumulator_now = kind_sum[kind];
    r.unit_total      = kind_units[kind];
    return r;
  endfunction

  task automatic send_item(input logic kind, input logic [PHASE_W-1:0] ph,
                           input logic [READING_W-1:0] rd, input logic lp);
    int gap;
    if (sender_gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    in_valid        <= 1'b1;
    in_mode         <= kind;
    in_phase_index  <= ph;
    in_reading      <= rd;
    in_load_present <= lp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_meter_step(kind, ph, rd, lp));
    readings_sent++;
  endtask

  task automatic send_sweep(input logic kind, input logic lp);
    int     p;
    int     slot;
    int     roll;
    longint step;
    for (p = 0; p < int'(SLOTS_PER_KIND); p++) begin
      roll = $urandom_range(99);
      if (roll < 3) begin
        step = longint'($urandom_range(0, int'(FULL_SPAN))) - (HALF_SPAN + 1);
      end else if (roll < 13) begin
        step = -longint'($urandom_range(0, 1500));
      end else begin
        step = longint'($urandom_range(0, 3000));
      end
      slot = int'(kind) * int'(SLOTS_PER_KIND) + p;
      meter_pos[slot] = meter_pos[slot] + READING_W'(step);
      send_item(kind, PHASE_W'(p), meter_pos[slot], lp);
    end
  endtask

  task automatic write_threshold(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] value);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ACTIVE_THR) kind_thr[MODE_ACTIVE] = value;
    else kind_thr[MODE_REACTIVE] = value;
    burst_left = 0;
  endtask

  task automatic test_directed();
    send_item(MODE_ACTIVE, PHASE_UNUSED, 24'hFFFFFF, 1'b1);
    send_item(MODE_REACTIVE, PHASE_UNUSED, 24'h000000, 1'b0);
    send_item(MODE_ACTIVE, 2'd0, 24'h000000, 1'b0);
    send_item(MODE_ACTIVE, 2'd1, 24'hFFFFFF, 1'b0);
    send_item(MODE_ACTIVE, PHASE_SWEEP_END, 24'h800000, 1'b1);
    send_item(MODE_REACTIVE, 2'd0, 24'h123456, 1'b0);
    send_item(MODE_REACTIVE, 2'd1, 24'h000001, 1'b1);
    send_item(MODE_REACTIVE, PHASE_SWEEP_END, 24'hFFFFFE, 1'b0);
    send_item(MODE_ACTIVE, 2'd0, 24'h7FFFFF, 1'b0);
    send_item(MODE_ACTIVE, 2'd0, 24'hFFFFFF, 1'b0);
    send_item(MODE_ACTIVE, 2'd0, 24'h7FFFFF, 1'b0);
    send_item(MODE_ACTIVE, 2'd0, 24'h7FFFFF, 1'b0);
    send_item(MODE_ACTIVE, 2'd1, 24'h000010, 1'b0);
    send_item(MODE_ACTIVE, 2'd1, 24'hFFFFF0, 1'b0);
    send_item(MODE_ACTIVE, PHASE_SWEEP_END, 24'h800000, 1'b0);
    send_item(MODE_ACTIVE, PHASE_SWEEP_END, 24'h800100, 1'b1);
    send_item(MODE_REACTIVE, PHASE_SWEEP_END, 24'hFFFFFE, 1'b0);
    send_item(MODE_REACTIVE, 2'd0, 24'h1220CE, 1'b0);
    send_item(MODE_REACTIVE, PHASE_SWEEP_END, 24'hFFFFFE, 1'b0);
    send_item(MODE_ACTIVE, PHASE_UNUSED, 24'h5A5A5A, 1'b1);
    send_item(MODE_REACTIVE, PHASE_UNUSED, 24'hA5A5A5, 1'b1);
  endtask

  task automatic test_random_sweeps(input logic [THR_W-1:0] active_thr,
                                    input logic [THR_W-1:0] reactive_thr, input int count);
    int start;
    write_threshold(CFG_ACTIVE_THR, active_thr);
    write_threshold(CFG_REACTIVE_THR, reactive_thr);
    start = readings_sent;
    while (readings_sent - start < count) begin
      if ($urandom_range(99) < 80) begin
        send_sweep(1'($urandom_range(1)), $urandom_range(99) < 75);
      end else begin
        send_item(1'($urandom_range(1)), PHASE_W'($urandom_range(3)),
                  READING_W'($urandom()), 1'($urandom_range(1)));
      end
    end
  endtask

  task automatic test_saturation();
    logic [READING_W-1:0] rd;
    int                   i;
    write_threshold(CFG_ACTIVE_THR, THR_MAX);
    write_threshold(CFG_REACTIVE_THR, THR_MAX);
    rd = slot_last[0];
    while (kind_sum[MODE_ACTIVE] != SUM_MAX) begin
      rd = rd + READING_W'(HALF_SPAN);
      send_item(MODE_ACTIVE, 2'd0, rd, 1'b1);
    end
    for (i = 0; i < 3; i++) begin
      rd = rd + READING_W'(HALF_SPAN);
      send_item(MODE_ACTIVE, 2'd0, rd, 1'b1);
    end
    send_item(MODE_ACTIVE, PHASE_SWEEP_END, slot_last[2], 1'b1);
    rd = slot_last[3];
    while (kind_sum[MODE_REACTIVE] != SUM_MIN) begin
      rd = rd - READING_W'(HALF_SPAN);
      send_item(MODE_REACTIVE, 2'd0, rd, 1'b0);
    end
    for (i = 0; i < 3; i++) begin
      rd = rd - READING_W'(HALF_SPAN);
      send_item(MODE_REACTIVE, 2'd0, rd, 1'b0);
    end
    send_item(MODE_REACTIVE, PHASE_SWEEP_END, slot_last[5], 1'b0);
  endtask

  task automatic test_zero_threshold();
    write_threshold(CFG_ACTIVE_THR, '0);
    write_threshold(CFG_REACTIVE_THR, '0);
    send_item(MODE_ACTIVE, PHASE_SWEEP_END, slot_last[2], 1'b1);
    send_item(MODE_ACTIVE, PHASE_SWEEP_END, slot_last[2], 1'b1);
    send_item(MODE_ACTIVE, PHASE_SWEEP_END, slot_last[2], 1'b0);
    send_item(MODE_REACTIVE, PHASE_SWEEP_END, slot_last[5], 1'b0);
    send_item(MODE_REACTIVE, 2'd0, slot_last[3] + READING_W'(1), 1'b0);
    send_item(MODE_REACTIVE, PHASE_SWEEP_END, slot_last[5], 1'b1);
  endtask

  task automatic test_backpressure();
    int i;
    sender_gaps_on = 1'b0;
    hold_req_count++;
    for (i = 0; i < 30; i++) send_sweep(1'($urandom_range(1)), 1'b1);
    sender_gaps_on = 1'b1;
  endtask

  initial begin : receiver
    int k;
    int stall_pct;
    int pattern_left;
    stall_pct    = 0;
    pattern_left = 0;
    forever begin
      @(posedge clk);
      if (hold_done_count != hold_req_count) begin
        hold_done_count++;
        out_stall <= 1'b1;
        for (k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        if (pattern_left == 0) begin
          pattern_left = $urandom_range(10, 150);
          case ($urandom_range(3))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end
        pattern_left--;
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    meter_result_t want;
    if (in_valid && in_stall) input_stall_cycles++;
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      if (out_unit_pulse === 1'b1) pulses_seen++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
          $display("%0t: result beat with nothing outstanding", $time);
        end
      end else begin
        want = pending_results.pop_front();
        if (out_delta_valid !== want.delta_valid || out_wrapped_delta !== want.wrapped_delta
            || out_accumulator_now !== want.accumulator_now
            || out_unit_pulse !== want.unit_pulse || out_unit_total !== want.unit_total) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: beat %0d expected valid=%0b delta=%0d acc=%0d pulse=%0b units=%0d",
                     $time, results_checked, want.delta_valid, want.wrapped_delta,
                     want.accumulator_now, want.unit_pulse, want.unit_total);
            $display("%0t: beat %0d actual   valid=%0b delta=%0d acc=%0d pulse=%0b units=%0d",
                     $time, results_checked, out_delta_valid, out_wrapped_delta,
                     out_accumulator_now, out_unit_pulse, out_unit_total);
          end
        end
      end
    end
  end

  initial begin : run_tests
    int i;
    for (i = 0; i < NUM_SLOTS; i++) begin
      slot_last[i] = '0;
      slot_seen[i] = 1'b0;
      meter_pos[i] = READING_W'($urandom());
    end
    kind_sum[MODE_ACTIVE]     = '0;
    kind_sum[MODE_REACTIVE]   = '0;
    kind_units[MODE_ACTIVE]   = '0;
    kind_units[MODE_REACTIVE] = '0;
    kind_thr[MODE_ACTIVE]     = THR_RESET;
    kind_thr[MODE_REACTIVE]   = THR_RESET;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_sweeps(THR_W'(1), THR_W'(1), 300);
    test_random_sweeps(THR_W'($urandom_range(200, 5000)), THR_W'($urandom_range(200, 5000)),
                       300);
    test_saturation();
    test_zero_threshold();
    test_random_sweeps(THR_MAX, THR_W'($urandom_range(1, 100000)), 250);
    test_random_sweeps(THR_RESET, THR_RESET, 300);
    test_backpressure();

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Covered %0d readings and %0d result beats with %0d unit pulses, wrap, saturation",
             readings_sent, results_checked, pulses_seen);
    $display("and zero to full-scale thresholds; input held off %0d cycles, %0d mismatches.",
             input_stall_cycles, mismatch_count);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> files.f
hdl/ecda_pkg.sv
hdl/energy_counter_delta_accumulator_unit.sv
sim/tb_top.sv
